/* design/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types, register codes and defaults of the noise pattern self-test.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

	// default geometry of the test
	localparam int SAMPLES_PER_LEVEL_DEF  = 50;
	localparam int LEVELS_PER_SECTION_DEF = 4;
	localparam int LEVELS_PER_TEST_DEF    = 200;

	localparam int SAMPLE_MAX = 255;

	// register reset values
	localparam logic [7:0] ZERO_OFFSET_RST      = 8'd125;
	localparam logic [7:0] LOUD_THRESHOLD_RST   = 8'd20;
	localparam logic [6:0] MAJORITY_PERCENT_RST = 7'd60;

	localparam logic [7:0] LEVEL_MAX    = 8'd255;
	localparam logic [6:0] PERCENT_FULL = 7'd100;

	// section pattern quiet, loud, quiet, loud
	localparam int PATTERN_LEN = 4;
	localparam int PROG_W      = $clog2(PATTERN_LEN + 1);

	// configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_ZERO_OFFSET      = 2'd0,
		REG_LOUD_THRESHOLD   = 2'd1,
		REG_MAJORITY_PERCENT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLASS_QUIET = 2'd0,
		CLASS_LOUD  = 2'd1,
		CLASS_UNDEF = 2'd2
	} section_class_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] raw_sample;
		logic       read_ok;
	} sample_t;

	typedef struct packed {
		logic [7:0]     average_level;
		logic           loud;
		logic           section_closed;
		section_class_t section_class;
		logic           test_done;
		logic           test_pass;
	} result_t;

	typedef struct packed {
		logic [7:0] zero_offset;
		logic [7:0] loud_threshold;
		logic [6:0] majority_percent;
	} cfg_t;

	// window end event handed from the accumulator to the level stage
	typedef struct packed {
		logic restart;
		logic read_err;
	} evt_t;

	// judged level handed to the section stage
	typedef struct packed {
		logic       restart;
		logic [7:0] level;
		logic       loud;
	} lvl_t;

endpackage

`default_nettype wire

/* design/nps_if.sv */
// ----------------------------------------------------------------------------
// nps_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_sample_if;
	logic              valid;
	logic              ready;
	nps_pkg::sample_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface nps_result_if;
	logic              valid;
	logic              ready;
	nps_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/nps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// nps_cfg_regs
// APB register file holding zero offset, loud threshold and majority percent.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [nps_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [nps_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [nps_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	output nps_pkg::cfg_t                       cfg
);
	import nps_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_offset      <= ZERO_OFFSET_RST;
			cfg_q.loud_threshold   <= LOUD_THRESHOLD_RST;
			cfg_q.majority_percent <= MAJORITY_PERCENT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ZERO_OFFSET: begin
					cfg_q.zero_offset <= pwdata[7:0];
				end
				REG_LOUD_THRESHOLD: begin
					cfg_q.loud_threshold <= pwdata[7:0];
				end
				REG_MAJORITY_PERCENT: begin
					cfg_q.majority_percent <= pwdata[6:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ZERO_OFFSET: begin
				prdata = APB_DATA_W'(cfg_q.zero_offset);
			end
			REG_LOUD_THRESHOLD: begin
				prdata = APB_DATA_W'(cfg_q.loud_threshold);
			end
			REG_MAJORITY_PERCENT: begin
				prdata = APB_DATA_W'(cfg_q.majority_percent);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/nps_window.sv */
// ----------------------------------------------------------------------------
// nps_window
// Input register and window accumulator; emits one event per window end.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_window #(
	parameter int SAMPLES_PER_LEVEL = nps_pkg::SAMPLES_PER_LEVEL_DEF,
	parameter int SUM_W             = 14
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	nps_sample_if.sink           sample,
	input  wire nps_pkg::cfg_t   cfg,
	input  wire logic            evt_take,
	output logic                 evt_valid,
	output nps_pkg::evt_t        evt,
	output logic [SUM_W-1:0]     evt_sum
);
	import nps_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES_PER_LEVEL);

	logic             valid_s1;
	sample_t          smp_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;

	logic             evt_valid_s2;
	evt_t             evt_s2;
	logic [SUM_W-1:0] sum_s2;

	logic [7:0]       mag;
	logic [SUM_W-1:0] sum_next;
	logic             last;
	logic             ends;
	logic             s2_free;
	logic             adv;

	// rectify about the zero offset
	always_comb begin
		if (smp_s1.raw_sample >= cfg.zero_offset) begin
			mag = smp_s1.raw_sample - cfg.zero_offset;
		end else begin
			mag = cfg.zero_offset - smp_s1.raw_sample;
		end
	end

	assign sum_next = sum_q + SUM_W'(mag);
	assign last     = (cnt_q == CNT_W'(SAMPLES_PER_LEVEL - 1));
	assign ends     = smp_s1.kind || !smp_s1.read_ok || last;

	// mid-window samples leave the stage without needing the next one
	assign s2_free      = !evt_valid_s2 || evt_take;
	assign adv          = valid_s1 && (!ends || s2_free);
	assign sample.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready) begin
			smp_s1 <= sample.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (adv) begin
			if (ends) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			evt_valid_s2 <= valid_s1 && ends;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			evt_s2.restart  <= smp_s1.kind;
			evt_s2.read_err <= !smp_s1.read_ok;
			sum_s2          <= sum_next;
		end
	end

	assign evt_valid = evt_valid_s2;
	assign evt       = evt_s2;
	assign evt_sum   = sum_s2;

endmodule

`default_nettype wire

/* design/nps_level.sv */
// ----------------------------------------------------------------------------
// nps_level
// Turns a window sum into a saturated level and judges it loud or quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_level #(
	parameter int SAMPLES_PER_LEVEL = nps_pkg::SAMPLES_PER_LEVEL_DEF,
	parameter int SUM_W             = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               evt_valid,
	input  wire nps_pkg::evt_t      evt,
	input  wire logic [SUM_W-1:0]   evt_sum,
	input  wire nps_pkg::cfg_t      cfg,
	output logic                    evt_take,
	input  wire logic               lvl_take,
	output logic                    lvl_valid,
	output nps_pkg::lvl_t           lvl
);
	import nps_pkg::*;

	// sum / DIV as a multiply by a rounded-up reciprocal, exact for any SUM_W-bit sum
	localparam int DIV    = SAMPLES_PER_LEVEL / 2;
	localparam int SHIFT  = SUM_W + $clog2(DIV);
	localparam int RECIP  = ((1 << SHIFT) + DIV - 1) / DIV;
	localparam int PROD_W = SUM_W + SHIFT + 1;

	localparam logic [SHIFT:0] RECIP_V = (SHIFT + 1)'(RECIP);

	logic              valid_s3;
	lvl_t              lvl_s3;
	logic              s3_free;
	logic [PROD_W-1:0] prod;
	logic [SUM_W:0]    quo;
	logic [7:0]        level;

	assign prod = PROD_W'(evt_sum) * PROD_W'(RECIP_V);
	assign quo  = prod[PROD_W-1:SHIFT];

	always_comb begin
		if (evt.read_err) begin
			level = '0;
		end else if (quo > (SUM_W + 1)'(LEVEL_MAX)) begin
			level = LEVEL_MAX;
		end else begin
			level = quo[7:0];
		end
	end

	assign s3_free  = !valid_s3 || lvl_take;
	assign evt_take = s3_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free) begin
			lvl_s3.restart <= evt.restart;
			lvl_s3.level   <= level;
			lvl_s3.loud    <= (level >= cfg.loud_threshold);
		end
	end

	assign lvl_valid = valid_s3;
	assign lvl       = lvl_s3;

endmodule

`default_nettype wire

/* design/nps_judge.sv */
// ----------------------------------------------------------------------------
// nps_judge
// Section classing, pattern matching, test end and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_judge #(
	parameter int LEVELS_PER_SECTION = nps_pkg::LEVELS_PER_SECTION_DEF,
	parameter int LEVELS_PER_TEST    = nps_pkg::LEVELS_PER_TEST_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            lvl_valid,
	input  wire nps_pkg::lvl_t   lvl,
	input  wire nps_pkg::cfg_t   cfg,
	output logic                 lvl_take,
	nps_result_if.source         result
);
	import nps_pkg::*;

	localparam int CNT_W   = $clog2(LEVELS_PER_SECTION + 1);
	localparam int LVL_W   = $clog2(LEVELS_PER_TEST + 1);
	localparam int SCORE_W = $clog2(127 * LEVELS_PER_SECTION + 1);

	logic [CNT_W-1:0]   loud_cnt_q;
	logic [CNT_W-1:0]   quiet_cnt_q;
	logic [LVL_W-1:0]   levels_q;
	logic [PROG_W-1:0]  progress_q;
	logic               finished_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [CNT_W-1:0]   loud_n;
	logic [CNT_W-1:0]   quiet_n;
	logic [LVL_W-1:0]   levels_n;
	logic [PROG_W-1:0]  prog_n;
	logic               at_limit;
	logic               closing;
	logic [SCORE_W-1:0] loud_score;
	logic [SCORE_W-1:0] quiet_score;
	logic [SCORE_W-1:0] need_score;
	section_class_t     cls;
	logic               match;
	logic               pass;
	logic               produce;
	logic               out_free;
	logic               upd;

	assign loud_n   = loud_cnt_q + CNT_W'(lvl.loud);
	assign quiet_n  = quiet_cnt_q + CNT_W'(!lvl.loud);
	assign levels_n = levels_q + 1'b1;
	assign at_limit = (levels_n >= LVL_W'(LEVELS_PER_TEST));

	// counts restart at every close, so a full section is reached when they add up
	assign closing = !at_limit
		&& ((CNT_W + 1)'(loud_n) + (CNT_W + 1)'(quiet_n) == (CNT_W + 1)'(LEVELS_PER_SECTION));

	// share >= percent, compared as count * 100 >= percent * section length
	assign loud_score  = SCORE_W'(loud_n) * SCORE_W'(PERCENT_FULL);
	assign quiet_score = SCORE_W'(quiet_n) * SCORE_W'(PERCENT_FULL);
	assign need_score  = SCORE_W'(cfg.majority_percent) * SCORE_W'(LEVELS_PER_SECTION);

	always_comb begin
		if (loud_score >= need_score) begin
			cls = CLASS_LOUD;
		end else if (quiet_score >= need_score) begin
			cls = CLASS_QUIET;
		end else begin
			cls = CLASS_UNDEF;
		end
	end

	// pattern alternates quiet, loud: the expected class follows the low progress bit
	assign match = closing && (cls == (progress_q[0] ? CLASS_LOUD : CLASS_QUIET));
	assign prog_n = progress_q + 1'b1;
	assign pass   = match && (prog_n >= PROG_W'(PATTERN_LEN));

	assign produce  = !lvl.restart && !finished_q;
	assign out_free = !res_valid_q || result.ready;
	assign lvl_take = !produce || out_free;
	assign upd      = lvl_valid && lvl_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loud_cnt_q  <= '0;
			quiet_cnt_q <= '0;
			levels_q    <= '0;
			progress_q  <= '0;
			finished_q  <= 1'b0;
		end else if (upd) begin
			if (lvl.restart) begin
				loud_cnt_q  <= '0;
				quiet_cnt_q <= '0;
				levels_q    <= '0;
				progress_q  <= '0;
				finished_q  <= 1'b0;
			end else if (!finished_q) begin
				loud_cnt_q  <= closing ? '0 : loud_n;
				quiet_cnt_q <= closing ? '0 : quiet_n;
				levels_q    <= levels_n;
				if (match) begin
					progress_q <= prog_n;
				end
				if (at_limit || pass) begin
					finished_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (upd && produce) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && produce) begin
			res_q.average_level  <= lvl.level;
			res_q.loud           <= lvl.loud;
			res_q.section_closed <= closing;
			res_q.section_class  <= closing ? cls : CLASS_QUIET;
			res_q.test_done      <= at_limit || pass;
			res_q.test_pass      <= pass;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

`default_nettype wire

/* design/noise_pattern_selftest_unit.sv */
// ----------------------------------------------------------------------------
// noise_pattern_selftest_unit
// Microphone self-test: window levels, section classes, pattern match.
// ----------------------------------------------------------------------------
// sample channel: one item per ADC read (kind 0) or a restart of the test
//   (kind 1); taken whenever sample.ready is high, one item per cycle.
// result channel: one item per finished window (SAMPLES_PER_LEVEL good reads
//   or one failed read) with level, loud flag, section class and test status;
//   no item for restarts, mid-window samples or samples after the test ended.
// path: the item that ends a window passes the input register, the
//   window-end register and the level register ahead of the result
//   register.
// throughput: 1 item per cycle while results are taken; the level multiply
//   and the section compare each sit in a stage of their own.
// stall: the result register holds its item until taken; samples that end no
//   window keep flowing, and sample.ready drops only once a window result
//   reaches a stage that cannot move on.
// reset: registers return to 125 / 20 / 60 and all test state is cleared at
//   once; there is no clearing pass. The APB port writes at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_pattern_selftest_unit #(
	parameter int SAMPLES_PER_LEVEL  = nps_pkg::SAMPLES_PER_LEVEL_DEF,
	parameter int LEVELS_PER_SECTION = nps_pkg::LEVELS_PER_SECTION_DEF,
	parameter int LEVELS_PER_TEST    = nps_pkg::LEVELS_PER_TEST_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	nps_sample_if.sink                          sample,
	nps_result_if.source                        result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [nps_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [nps_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [nps_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);
	import nps_pkg::*;

	localparam int SUM_W = $clog2(SAMPLES_PER_LEVEL * SAMPLE_MAX + 1);

	cfg_t             cfg;
	logic             evt_valid;
	logic             evt_take;
	evt_t             evt;
	logic [SUM_W-1:0] evt_sum;
	logic             lvl_valid;
	logic             lvl_take;
	lvl_t             lvl;

	nps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nps_window #(
		.SAMPLES_PER_LEVEL (SAMPLES_PER_LEVEL),
		.SUM_W             (SUM_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cfg       (cfg),
		.evt_take  (evt_take),
		.evt_valid (evt_valid),
		.evt       (evt),
		.evt_sum   (evt_sum)
	);

	nps_level #(
		.SAMPLES_PER_LEVEL (SAMPLES_PER_LEVEL),
		.SUM_W             (SUM_W)
	) u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt       (evt),
		.evt_sum   (evt_sum),
		.cfg       (cfg),
		.evt_take  (evt_take),
		.lvl_take  (lvl_take),
		.lvl_valid (lvl_valid),
		.lvl       (lvl)
	);

	nps_judge #(
		.LEVELS_PER_SECTION (LEVELS_PER_SECTION),
		.LEVELS_PER_TEST    (LEVELS_PER_TEST)
	) u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lvl_valid (lvl_valid),
		.lvl       (lvl),
		.cfg       (cfg),
		.lvl_take  (lvl_take),
		.result    (result)
	);

	// an empty result register lets every stage move, so input is never held
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("sample stalled with empty result register");

	a_pass_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.test_pass |-> result.data.test_done)
		else $error("pass reported without test end");

	a_class_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.section_closed
			|-> result.data.section_class == CLASS_QUIET)
		else $error("section class set on an open section");

	a_loud_matches_level: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid
			|-> result.data.loud == (result.data.average_level >= cfg.loud_threshold))
		else $error("loud flag disagrees with level and threshold");

endmodule

`default_nettype wire
